### hw/rtl/ajb_pkg.sv
package ajb_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int OVF_W      = 16;
    localparam int UF_W       = 11;
    localparam int PF_W       = 4;
    localparam int LIM_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [PF_W-1:0]      PF_RESET  = 4'd7;
    localparam logic [LIM_W-1:0]     LIM_RESET = 10'd200;
    localparam logic [UF_W-1:0]      UF_MAX    = 11'd2047;
    localparam logic [OVF_W-1:0]     OVF_MAX   = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_PREFETCH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UF_LIMIT = 1'd1;

    typedef enum logic [1:0] {
        OP_PUT = 2'd0,
        OP_GET = 2'd1,
        OP_EOP = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_BUFFERING = 2'd1,
        MODE_PLAYING   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_EOP   = 2'd1,
        KIND_FRAME = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PUT_OK      = 2'd0,
        PUT_FULL    = 2'd1,
        PUT_IGNORED = 2'd2
    } status_t;

    // request from the controller to the output side
    typedef struct packed {
        logic    single;
        logic    frame;
        logic    play;
        kind_t   kind;
        status_t status;
    } req_t;

    // state after the current step, shown in every word
    typedef struct packed {
        mode_t             mode;
        logic [OVF_W-1:0]  ovf;
    } stat_t;

endpackage

### hw/rtl/ajb_ram.sv
module ajb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 480
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/ajb_ctrl.sv
module ajb_ctrl #(
    parameter int FRAME_SIZE = 32,
    parameter int RING_LEN   = 480,
    parameter int PTR_W      = 9
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [1:0]                      op,
    input  logic [ajb_pkg::SAMPLE_W-1:0]    sample_in,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ajb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ajb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            can_accept,
    output ajb_pkg::req_t                   req,
    output ajb_pkg::stat_t                  stat,
    output logic [PTR_W-1:0]                frame_base,
    output logic                            wr_en,
    output logic [PTR_W-1:0]                wr_addr,
    output logic [ajb_pkg::SAMPLE_W-1:0]    wr_data
);

    localparam int PFT_W = ajb_pkg::PF_W + $clog2(FRAME_SIZE + 1);
    localparam int AV_W  = PTR_W + 1;
    localparam int CMP_W = (AV_W > PFT_W) ? AV_W : PFT_W;

    logic [PTR_W-1:0]              wp_reg, wp_next, rp_reg, rp_next;
    ajb_pkg::mode_t                mode_reg, mode_next;
    logic [ajb_pkg::UF_W-1:0]      uf_reg, uf_next;
    logic                          pend_reg, pend_next;
    logic [ajb_pkg::OVF_W-1:0]     ovf_reg, ovf_next;
    logic [ajb_pkg::PF_W-1:0]      pf_reg, pf_next;
    logic [ajb_pkg::LIM_W-1:0]     lim_reg, lim_next;

    logic                          accept;
    logic [AV_W-1:0]               avail, wp_inc, rp_adv;
    logic [PFT_W-1:0]              thresh;
    logic [ajb_pkg::UF_W-1:0]      uf_bump;
    logic                          full;

    assign accept    = s_axis_tvalid && can_accept;
    assign s_axis_tready = can_accept;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            avail = {1'b0, wp_reg} - {1'b0, rp_reg};
        end
        else
        begin
            avail = AV_W'(RING_LEN) - {1'b0, rp_reg} + {1'b0, wp_reg};
        end
        wp_inc = {1'b0, wp_reg} + AV_W'(1);
        if (wp_inc >= AV_W'(RING_LEN))
        begin
            wp_inc = '0;
        end
        rp_adv = {1'b0, rp_reg} + AV_W'(FRAME_SIZE);
        if (rp_adv >= AV_W'(RING_LEN))
        begin
            rp_adv = '0;
        end
    end

    assign thresh  = PFT_W'(pf_reg) * PFT_W'(FRAME_SIZE);
    assign full    = (wp_inc[PTR_W-1:0] == rp_reg);
    assign uf_bump = (uf_reg == ajb_pkg::UF_MAX) ? uf_reg : uf_reg + 1'b1;

    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        mode_next  = mode_reg;
        uf_next    = uf_reg;
        pend_next  = pend_reg;
        ovf_next   = ovf_reg;
        pf_next    = pf_reg;
        lim_next   = lim_reg;
        wr_en      = 1'b0;
        req.single = 1'b0;
        req.frame  = 1'b0;
        req.play   = 1'b0;
        req.kind   = ajb_pkg::KIND_PUT;
        req.status = ajb_pkg::PUT_OK;

        if (cfg_valid)
        begin
            case (cfg_index)
                ajb_pkg::REG_PREFETCH: pf_next  = cfg_data[ajb_pkg::PF_W-1:0];
                ajb_pkg::REG_UF_LIMIT: lim_next = cfg_data[ajb_pkg::LIM_W-1:0];
                default: ;
            endcase
        end

        if (accept)
        begin
            case (op)
                ajb_pkg::OP_PUT:
                begin
                    req.single = 1'b1;
                    req.kind   = ajb_pkg::KIND_PUT;
                    if (pend_reg)
                    begin
                        req.status = ajb_pkg::PUT_IGNORED;
                    end
                    else if (full)
                    begin
                        req.status = ajb_pkg::PUT_FULL;
                        if (ovf_reg != ajb_pkg::OVF_MAX)
                        begin
                            ovf_next = ovf_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wp_next = wp_inc[PTR_W-1:0];
                        if (mode_reg == ajb_pkg::MODE_IDLE)
                        begin
                            mode_next = ajb_pkg::MODE_BUFFERING;
                        end
                    end
                end
                ajb_pkg::OP_EOP:
                begin
                    req.single = 1'b1;
                    req.kind   = ajb_pkg::KIND_EOP;
                    if (pend_reg)
                    begin
                        pend_next = 1'b0;
                        wp_next   = '0;
                    end
                end
                ajb_pkg::OP_GET:
                begin
                    req.frame = 1'b1;
                    req.kind  = ajb_pkg::KIND_FRAME;
                    case (mode_reg)
                        ajb_pkg::MODE_BUFFERING:
                        begin
                            if (CMP_W'(avail) >= CMP_W'(thresh))
                            begin
                                mode_next = ajb_pkg::MODE_PLAYING;
                            end
                            else
                            begin
                                uf_next = uf_bump;
                                // too many starved gets: drop to idle, ask for reset
                                if (uf_bump > ajb_pkg::UF_W'(lim_reg))
                                begin
                                    mode_next = ajb_pkg::MODE_IDLE;
                                    uf_next   = '0;
                                    rp_next   = '0;
                                    pend_next = 1'b1;
                                end
                            end
                        end
                        ajb_pkg::MODE_PLAYING:
                        begin
                            if (avail < AV_W'(FRAME_SIZE))
                            begin
                                mode_next = ajb_pkg::MODE_BUFFERING;
                                uf_next   = uf_bump;
                            end
                            else
                            begin
                                uf_next = '0;
                            end
                        end
                        default: ;
                    endcase
                    if (mode_next == ajb_pkg::MODE_PLAYING)
                    begin
                        req.play = 1'b1;
                        rp_next  = rp_adv[PTR_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign frame_base = rp_reg;
    assign wr_addr    = wp_reg;
    assign wr_data    = sample_in;
    assign stat.mode  = mode_next;
    assign stat.ovf   = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            mode_reg <= ajb_pkg::MODE_IDLE;
            uf_reg   <= '0;
            pend_reg <= 1'b0;
            ovf_reg  <= '0;
            pf_reg   <= ajb_pkg::PF_RESET;
            lim_reg  <= ajb_pkg::LIM_RESET;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            mode_reg <= mode_next;
            uf_reg   <= uf_next;
            pend_reg <= pend_next;
            ovf_reg  <= ovf_next;
            pf_reg   <= pf_next;
            lim_reg  <= lim_next;
        end
    end

endmodule

### hw/rtl/ajb_stream.sv
module ajb_stream #(
    parameter int FRAME_SIZE = 32,
    parameter int PTR_W      = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ajb_pkg::req_t                 req,
    input  ajb_pkg::stat_t                stat,
    input  logic [PTR_W-1:0]              frame_base,
    output logic                          can_accept,
    output logic                          rd_en,
    output logic [PTR_W-1:0]              rd_addr,
    input  logic [ajb_pkg::SAMPLE_W-1:0]  rd_data,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,
    output logic [2:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);

    localparam int CNT_W = $clog2(FRAME_SIZE + 1);

    logic                          busy_reg, busy_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic [PTR_W-1:0]              base_reg, base_next;
    logic                          play_reg, play_next;
    logic                          pend_reg, pend_next;
    logic                          pend_last_reg, pend_last_next;

    logic                          valid_reg, valid_next;
    ajb_pkg::kind_t                kind_reg, kind_next;
    ajb_pkg::status_t              status_reg, status_next;
    logic [ajb_pkg::SAMPLE_W-1:0]  smp_reg, smp_next;
    logic                          fb_reg, fb_next;
    logic                          last_reg, last_next;
    ajb_pkg::mode_t                mode_reg, mode_next;
    logic [ajb_pkg::OVF_W-1:0]     ovf_reg, ovf_next;

    logic                          out_free, load_pend;

    assign out_free   = !valid_reg || m_axis_tready;
    assign load_pend  = pend_reg && out_free;
    assign can_accept = !busy_reg && out_free;
    // a new read only when the word already in the RAM output register moves on
    assign rd_en      = busy_reg && (idx_reg != CNT_W'(FRAME_SIZE)) && (!pend_reg || load_pend);
    assign rd_addr    = base_reg + PTR_W'(idx_reg);

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        play_next      = play_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        valid_next     = valid_reg;
        kind_next      = kind_reg;
        status_next    = status_reg;
        smp_next       = smp_reg;
        fb_next        = fb_reg;
        last_next      = last_reg;
        mode_next      = mode_reg;
        ovf_next       = ovf_reg;

        if (valid_reg && m_axis_tready)
        begin
            valid_next = 1'b0;
        end

        if (req.frame)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            base_next = frame_base;
            play_next = req.play;
        end

        if (load_pend)
        begin
            pend_next = 1'b0;
            if (pend_last_reg)
            begin
                busy_next = 1'b0;
            end
        end

        if (rd_en)
        begin
            pend_next      = 1'b1;
            pend_last_next = (idx_reg == CNT_W'(FRAME_SIZE - 1));
            idx_next       = idx_reg + 1'b1;
        end

        if (req.single)
        begin
            valid_next  = 1'b1;
            kind_next   = req.kind;
            status_next = req.status;
            smp_next    = '0;
            fb_next     = 1'b0;
            last_next   = 1'b1;
            mode_next   = stat.mode;
            ovf_next    = stat.ovf;
        end
        else if (load_pend)
        begin
            valid_next  = 1'b1;
            kind_next   = ajb_pkg::KIND_FRAME;
            status_next = ajb_pkg::PUT_OK;
            smp_next    = play_reg ? rd_data : '0;
            fb_next     = play_reg;
            last_next   = pend_last_reg;
            mode_next   = stat.mode;
            ovf_next    = stat.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        base_reg      <= base_next;
        play_reg      <= play_next;
        pend_last_reg <= pend_last_next;
        kind_reg      <= kind_next;
        status_reg    <= status_next;
        smp_reg       <= smp_next;
        fb_reg        <= fb_next;
        last_reg      <= last_next;
        mode_reg      <= mode_next;
        ovf_reg       <= ovf_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'b0, ovf_reg, mode_reg, smp_reg, status_reg};
    assign m_axis_tuser  = {fb_reg, kind_reg};
    assign m_axis_tlast  = last_reg;

endmodule

### hw/rtl/audio_jitter_buffer.sv
// Audio jitter buffer: a ring of FRAME_SIZE * BUFFER_FRAMES 16-bit samples
// in one RAM. Input words carry op in s_axis_tuser and the sample in
// s_axis_tdata. A put or end-of-packet returns one word; puts stream at
// one per cycle when the output is taken. A get returns FRAME_SIZE words,
// one per cycle from the single RAM read port while the output is taken,
// and the next input word is taken once the last frame word sits in the
// output register. Playback starts after prefetch_frames frames are stored
// (config index 0) and a run of starved gets beyond underflow_limit
// (config index 1) forces idle and a reset request that the next
// end-of-packet clears.
module audio_jitter_buffer #(
    parameter int FRAME_SIZE    = 32,
    parameter int BUFFER_FRAMES = 15
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // sample_in
    input  logic [1:0]                      s_axis_tuser,  // op
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // put_status[1:0], sample_out[17:2], play_state[19:18],
    // overflow_total[35:20], zero[39:36]
    output logic [39:0]                     m_axis_tdata,
    output logic [2:0]                      m_axis_tuser,  // kind[1:0], from_buffer[2]
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ajb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ajb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int RING_LEN = FRAME_SIZE * BUFFER_FRAMES;
    localparam int PTR_W    = $clog2(RING_LEN);

    ajb_pkg::req_t                 req;
    ajb_pkg::stat_t                stat;
    logic [PTR_W-1:0]              frame_base;
    logic                          can_accept;
    logic                          wr_en, rd_en;
    logic [PTR_W-1:0]              wr_addr, rd_addr;
    logic [ajb_pkg::SAMPLE_W-1:0]  wr_data, rd_data;

    ajb_ctrl #(
        .FRAME_SIZE (FRAME_SIZE),
        .RING_LEN   (RING_LEN),
        .PTR_W      (PTR_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .op            (s_axis_tuser),
        .sample_in     (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .can_accept    (can_accept),
        .req           (req),
        .stat          (stat),
        .frame_base    (frame_base),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    ajb_ram #(
        .WIDTH (ajb_pkg::SAMPLE_W),
        .DEPTH (RING_LEN)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ajb_stream #(
        .FRAME_SIZE (FRAME_SIZE),
        .PTR_W      (PTR_W)
    ) u_stream (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .stat          (stat),
        .frame_base    (frame_base),
        .can_accept    (can_accept),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // a frame in progress blocks new input words
    a_frame_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        req.frame |=> !s_axis_tready)
        else $error("input accepted right after a get");

    // ring writes only happen between frames, never against a frame read
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("RAM write during frame read");

    // single-word results always close their input
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == ajb_pkg::KIND_PUT ||
                          m_axis_tuser[1:0] == ajb_pkg::KIND_EOP) |-> m_axis_tlast)
        else $error("put/eop word without tlast");

    // ring data only shows in frame words
    a_fb_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ajb_pkg::KIND_FRAME)
        else $error("from_buffer set on a non-frame word");
`endif

endmodule

### tb/tb.sv
module tb;

    localparam int FRAME_SIZE    = 32;
    localparam int BUFFER_FRAMES = 15;
    localparam int RING_LEN      = FRAME_SIZE * BUFFER_FRAMES;
    localparam int SETTLE_CYCLES = 2 * FRAME_SIZE + 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] sample;
    } jb_cmd_t;

    typedef struct packed {
        ajb_pkg::kind_t             kind;
        ajb_pkg::status_t           status;
        logic [15:0]                smp;
        logic                       fb;
        logic                       last;
        ajb_pkg::mode_t             mode;
        logic [ajb_pkg::OVF_W-1:0]  ovf;
    } jb_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [15:0]                     s_axis_tdata = '0;   // sample_in
    logic [1:0]                      s_axis_tuser = '0;   // op
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // put_status, sample_out, play_state, overflow_total, zero pad
    logic [39:0]                     m_axis_tdata;
    logic [2:0]                      m_axis_tuser;        // kind, from_buffer
    logic                            m_axis_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ajb_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ajb_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    audio_jitter_buffer #(
        .FRAME_SIZE    (FRAME_SIZE),
        .BUFFER_FRAMES (BUFFER_FRAMES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // buffer state as predicted
    logic [15:0]                 ring [RING_LEN];
    logic [8:0]                  wr_ptr = '0;
    logic [8:0]                  rd_ptr = '0;
    ajb_pkg::mode_t              play_mode = ajb_pkg::MODE_IDLE;
    logic [ajb_pkg::UF_W-1:0]    uf_cnt = '0;
    logic                        rst_req = 1'b0;
    logic [ajb_pkg::OVF_W-1:0]   ovf_cnt = '0;
    logic [ajb_pkg::PF_W-1:0]    pf_frames = ajb_pkg::PF_RESET;
    logic [ajb_pkg::LIM_W-1:0]   uf_limit = ajb_pkg::LIM_RESET;

    jb_cmd_t  pending_cmds[$];
    jb_word_t predicted_words[$];

    int cmds_queued = 0;
    int cmds_taken = 0;
    int n_words = 0;
    int n_errors = 0;
    int n_drops = 0;
    int n_resets = 0;
    int n_ring_frames = 0;
    int send_gap = 0;
    int recv_stall = 0;
    bit bursty = 1'b1;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void buffer_step(input jb_cmd_t c);
        jb_word_t w;
        int       nxt;
        int       avail;
        int       base;
        w = '0;
        w.last = 1'b1;
        if (c.op == ajb_pkg::OP_PUT)
        begin
            w.kind = ajb_pkg::KIND_PUT;
            if (rst_req)
                w.status = ajb_pkg::PUT_IGNORED;
            else
            begin
                nxt = int'(wr_ptr) + 1;
                if (nxt >= RING_LEN)
                    nxt = 0;
                if (nxt == int'(rd_ptr))
                begin
                    if (ovf_cnt != ajb_pkg::OVF_MAX)
                        ovf_cnt = ovf_cnt + 1'b1;
                    w.status = ajb_pkg::PUT_FULL;
                    n_drops++;
                end
                else
                begin
                    ring[wr_ptr] = c.sample;
                    wr_ptr = 9'(nxt);
                    if (play_mode == ajb_pkg::MODE_IDLE)
                        play_mode = ajb_pkg::MODE_BUFFERING;
                    w.status = ajb_pkg::PUT_OK;
                end
            end
            w.mode = play_mode;
            w.ovf = ovf_cnt;
            predicted_words.push_back(w);
        end
        else if (c.op == ajb_pkg::OP_EOP)
        begin
            if (rst_req)
            begin
                rst_req = 1'b0;
                wr_ptr = '0;
            end
            w.kind = ajb_pkg::KIND_EOP;
            w.mode = play_mode;
            w.ovf = ovf_cnt;
            predicted_words.push_back(w);
        end
        else if (c.op == ajb_pkg::OP_GET)
        begin
            if (wr_ptr >= rd_ptr)
                avail = int'(wr_ptr) - int'(rd_ptr);
            else
                avail = RING_LEN - (int'(rd_ptr) - int'(wr_ptr));
            if (play_mode == ajb_pkg::MODE_BUFFERING)
            begin
                if (avail >= int'(pf_frames) * FRAME_SIZE)
                    play_mode = ajb_pkg::MODE_PLAYING;
                else
                begin
                    if (uf_cnt != ajb_pkg::UF_MAX)
                        uf_cnt = uf_cnt + 1'b1;
                    if (uf_cnt > uf_limit)
                    begin
                        play_mode = ajb_pkg::MODE_IDLE;
                        uf_cnt = '0;
                        rd_ptr = '0;
                        rst_req = 1'b1;
                        n_resets++;
                    end
                end
            end
            else if (play_mode == ajb_pkg::MODE_PLAYING)
            begin
                // starved while playing: fall back, no limit check here
                if (avail < FRAME_SIZE)
                begin
                    play_mode = ajb_pkg::MODE_BUFFERING;
                    if (uf_cnt != ajb_pkg::UF_MAX)
                        uf_cnt = uf_cnt + 1'b1;
                end
                else
                    uf_cnt = '0;
            end
            base = int'(rd_ptr);
            if (play_mode == ajb_pkg::MODE_PLAYING)
            begin
                rd_ptr = (base + FRAME_SIZE >= RING_LEN) ? 9'd0 : 9'(base + FRAME_SIZE);
                n_ring_frames++;
            end
            for (int i = 0; i < FRAME_SIZE; i++)
            begin
                w = '0;
                w.kind = ajb_pkg::KIND_FRAME;
                w.last = (i == FRAME_SIZE - 1);
                w.mode = play_mode;
                w.ovf = ovf_cnt;
                if (play_mode == ajb_pkg::MODE_PLAYING)
                begin
                    w.smp = ring[(base + i) % RING_LEN];
                    w.fb = 1'b1;
                end
                predicted_words.push_back(w);
            end
        end
    endfunction

    // input side
    always @(posedge clk)
    begin : feed
        jb_cmd_t c;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                c.op = s_axis_tuser;
                c.sample = s_axis_tdata;
                buffer_step(c);
                cmds_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (bursty && pending_cmds.size() != 0 && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 2);
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    c = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= c.op;
                    s_axis_tdata <= c.sample;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side
    always @(posedge clk)
    begin : watch
        jb_word_t got;
        jb_word_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind = ajb_pkg::kind_t'(m_axis_tuser[1:0]);
                got.status = ajb_pkg::status_t'(m_axis_tdata[1:0]);
                got.smp = m_axis_tdata[17:2];
                got.fb = m_axis_tuser[2];
                got.last = m_axis_tlast;
                got.mode = ajb_pkg::mode_t'(m_axis_tdata[19:18]);
                got.ovf = m_axis_tdata[35:20];
                n_words++;
                if (predicted_words.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected word %0d: kind=%0d st=%0d smp=%h fb=%0d",
                                 n_words, got.kind, got.status, got.smp, got.fb);
                end
                else
                begin
                    want = predicted_words.pop_front();
                    if (got.kind !== want.kind || got.status !== want.status ||
                        got.smp !== want.smp || got.fb !== want.fb ||
                        got.last !== want.last || got.mode !== want.mode ||
                        got.ovf !== want.ovf)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                        begin
                            $display("#%0d exp k=%0d s=%0d d=%h fb=%0d l=%0d m=%0d o=%0d",
                                     n_words, want.kind, want.status, want.smp, want.fb,
                                     want.last, want.mode, want.ovf);
                            $display("#%0d got k=%0d s=%0d d=%h fb=%0d l=%0d m=%0d o=%0d",
                                     n_words, got.kind, got.status, got.smp, got.fb,
                                     got.last, got.mode, got.ovf);
                        end
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (bursty && $urandom_range(0, 7) == 0)
            begin
                recv_stall = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 15))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void queue_cmd(input logic [1:0] op, input logic [15:0] sample);
        jb_cmd_t c;
        c.op = op;
        c.sample = sample;
        pending_cmds.push_back(c);
        cmds_queued++;
    endfunction

    function automatic void queue_puts(input int n);
        repeat (n) queue_cmd(ajb_pkg::OP_PUT, rand_sample());
    endfunction

    // mostly fill/play/starve sequences, some end-of-packet and junk ops
    function automatic void queue_traffic(input int budget);
        int added;
        int n;
        int k;
        added = 0;
        while (added < budget)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    n = int'(pf_frames) * FRAME_SIZE + int'($urandom_range(0, 40)) - 8;
                    if (n > budget - added)
                        n = budget - added;
                    queue_puts(n);
                    queue_cmd(ajb_pkg::OP_GET, rand_sample());
                    added += n + 1;
                end
                3, 4:
                begin
                    k = $urandom_range(2, 4);
                    for (int j = 0; j < k && added < budget; j++)
                    begin
                        n = $urandom_range(28, 40);
                        if (n > budget - added)
                            n = budget - added;
                        queue_puts(n);
                        queue_cmd(ajb_pkg::OP_GET, rand_sample());
                        added += n + 1;
                    end
                end
                5, 6:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) queue_cmd(ajb_pkg::OP_GET, rand_sample());
                    added += n;
                end
                7:
                begin
                    queue_cmd(ajb_pkg::OP_EOP, rand_sample());
                    added++;
                end
                8:
                begin
                    queue_cmd(OP_UNUSED, rand_sample());
                    n = $urandom_range(1, 4);
                    queue_puts(n);
                    added += n + 1;
                end
                default:
                begin
                    queue_cmd(ajb_pkg::OP_PUT,
                              ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000);
                    added++;
                end
            endcase
        end
    endfunction

    // the last word out does not prove the block is done (op 3 words leave nothing)
    task automatic wait_idle();
        while (cmds_taken != cmds_queued || predicted_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [ajb_pkg::PF_W-1:0] pf,
                             input logic [ajb_pkg::LIM_W-1:0] lim);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= ajb_pkg::REG_PREFETCH;
        cfg_data <= ajb_pkg::CFG_DATA_W'(pf);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        pf_frames = pf;
        cfg_index <= ajb_pkg::REG_UF_LIMIT;
        cfg_data <= lim;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        uf_limit = lim;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings
        queue_cmd(OP_UNUSED, 16'hFFFF);
        queue_cmd(ajb_pkg::OP_EOP, 16'h0000);
        queue_cmd(ajb_pkg::OP_GET, 16'hFFFF);
        queue_cmd(ajb_pkg::OP_PUT, 16'h0000);
        queue_cmd(ajb_pkg::OP_PUT, 16'hFFFF);
        queue_cmd(ajb_pkg::OP_PUT, 16'h5555);
        queue_cmd(ajb_pkg::OP_PUT, 16'hAAAA);
        queue_cmd(ajb_pkg::OP_GET, 16'h0000);
        queue_cmd(OP_UNUSED, 16'h0000);
        queue_cmd(ajb_pkg::OP_EOP, 16'hFFFF);

        // one frame plays, then starvation trips the reset request
        configure(4'd1, 10'd1);
        queue_puts(FRAME_SIZE - 4);
        queue_cmd(ajb_pkg::OP_GET, rand_sample());
        queue_cmd(ajb_pkg::OP_GET, rand_sample());
        queue_cmd(ajb_pkg::OP_GET, rand_sample());
        queue_cmd(ajb_pkg::OP_PUT, 16'h1234);
        queue_cmd(ajb_pkg::OP_GET, rand_sample());
        queue_cmd(ajb_pkg::OP_EOP, rand_sample());
        queue_cmd(ajb_pkg::OP_PUT, 16'h8001);
        queue_traffic(60);

        bursty = 1'b0;
        configure(4'd2, 10'd5);
        queue_traffic(60);

        bursty = 1'b1;
        configure(4'($urandom_range(1, 2)), 10'($urandom_range(2, 12)));
        queue_traffic(60);

        // last part runs with no idling
        bursty = 1'b0;
        configure(4'd2, 10'd3);
        queue_traffic(55);
        wait_idle();

        $display("Checked %0d output words from %0d commands; %0d frames played from the ring.",
                 n_words, cmds_taken, n_ring_frames);
        $display("%0d puts dropped on a full ring, %0d reset requests, %0d mismatches.",
                 n_drops, n_resets, n_errors);
        if (n_errors == 0 && predicted_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/ajb_pkg.sv
hw/rtl/ajb_ram.sv
hw/rtl/ajb_ctrl.sv
hw/rtl/ajb_stream.sv
hw/rtl/audio_jitter_buffer.sv
tb/tb.sv
